@@ rtl/i2cms_pkg.sv @@
`default_nettype none

package i2cms_pkg;

  // Bus command codes as they arrive on the opcode field
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_SEND_ADDR = 3'd2,
    OP_SEND_BYTE = 3'd3,
    OP_RECV_ACK  = 3'd4,
    OP_RECV_NACK = 3'd5
  } opcode_e;

  // Class of pin sequence the back end runs
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_BYTE  = 2'd2
  } cmd_kind_e;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] READ_BIT = 8'h01;

  // Bits clocked per byte command: eight data bits and the acknowledge bit
  localparam int unsigned BYTE_BITS = 9;
  localparam logic [3:0]  LAST_BIT  = 4'(BYTE_BITS - 1);

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // Classified command as queued between front and back end
  typedef struct packed {
    cmd_kind_e  kind;
    logic       recv;    // receive: skip SDA writes on bits one to seven
    logic       fill;    // level shifted in behind the byte, driven on ack bit
    logic [7:0] sh;      // SDA levels, MSB first
    logic [7:0] rx_val;  // reported on the last pin write of a receive
    logic       ack_val; // reported on the last pin write of a send
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/i2cms_front.sv @@
`default_nettype none

module i2cms_front
  import i2cms_pkg::*;
(
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] opcode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       read_direction_i,
  input  wire logic [7:0] slave_bits_i,
  input  wire logic       slave_ack_level_i,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic known;

  // Classify the command; unused opcodes are accepted and dropped
  always_comb begin
    known          = 1'b1;
    cmd_o.kind     = KIND_BYTE;
    cmd_o.recv     = 1'b0;
    cmd_o.fill     = 1'b1;
    cmd_o.sh       = tx_byte_i;
    cmd_o.rx_val   = '0;
    cmd_o.ack_val  = 1'b0;
    unique case (opcode_i)
      OP_START: begin
        cmd_o.kind = KIND_START;
      end
      OP_STOP: begin
        cmd_o.kind = KIND_STOP;
      end
      OP_SEND_ADDR: begin
        cmd_o.sh      = read_direction_i ? (tx_byte_i | READ_BIT) : tx_byte_i;
        cmd_o.ack_val = slave_ack_level_i;
      end
      OP_SEND_BYTE: begin
        cmd_o.ack_val = slave_ack_level_i;
      end
      OP_RECV_ACK, OP_RECV_NACK: begin
        cmd_o.recv   = 1'b1;
        cmd_o.fill   = (opcode_i == OP_RECV_NACK);
        cmd_o.sh     = MSB_MASK;  // first write releases SDA
        cmd_o.rx_val = slave_bits_i;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && known;

endmodule

`default_nettype wire

@@ rtl/i2cms_cmd_fifo.sv @@
`default_nettype none

module i2cms_cmd_fifo
  import i2cms_pkg::*;
#(
  parameter int unsigned Depth = CMD_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      head_valid_o,
  output cmd_t      head_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntFull);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full command queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i) else $error("pop from empty command queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull) else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/i2cms_back.sv @@
`default_nettype none

module i2cms_back
  import i2cms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire cmd_t       head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic            last_of_command_o,
  output logic [7:0]      rx_byte_o,
  output logic            ack_sampled_o
);

  // Running command and pin state
  logic       busy_q;
  cmd_t       cmd_q, cmd_d;
  logic [3:0] bit_q;
  logic [1:0] ph_q;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  // Output register
  logic       out_valid_q;
  logic       out_scl_q, out_sda_q, out_last_q, out_ack_q;
  logic [7:0] out_rx_q;

  cmd_t       cur_cmd;
  logic [3:0] cur_bit, nxt_bit;
  logic [1:0] cur_ph, nxt_ph;
  logic [7:0] nxt_sh;
  logic       last;
  logic       step_go;

  // A new command starts straight from the queue head, no bubble
  assign cur_cmd = busy_q ? cmd_q : head_i;
  assign cur_bit = busy_q ? bit_q : '0;
  assign cur_ph  = busy_q ? ph_q  : '0;

  assign step_go = (busy_q || head_valid_i) && (!out_valid_q || !out_stall_i);
  assign pop_o   = step_go && !busy_q;

  // One pin write per step, then advance the step position
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    last    = 1'b0;
    nxt_bit = cur_bit;
    nxt_ph  = cur_ph + 2'd1;
    nxt_sh  = cur_cmd.sh;
    unique case (cur_cmd.kind)
      KIND_START: begin
        unique case (cur_ph)
          2'd0: sda_d = 1'b1;
          2'd1: scl_d = 1'b1;
          2'd2: sda_d = 1'b0;
          default: begin
            scl_d = 1'b0;
            last  = 1'b1;
          end
        endcase
      end
      KIND_STOP: begin
        unique case (cur_ph)
          2'd0: sda_d = 1'b0;
          2'd1: scl_d = 1'b1;
          default: begin
            sda_d = 1'b1;
            last  = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (cur_ph)
          2'd0: sda_d = cur_cmd.sh[7];
          2'd1: scl_d = 1'b1;
          default: begin
            scl_d   = 1'b0;
            last    = (cur_bit == LAST_BIT);
            nxt_bit = cur_bit + 4'd1;
            nxt_sh  = {cur_cmd.sh[6:0], cur_cmd.fill};
            // receive leaves SDA released on data bits after the first
            nxt_ph  = (cur_cmd.recv && nxt_bit != LAST_BIT) ? 2'd1 : 2'd0;
          end
        endcase
      end
    endcase
    cmd_d    = cur_cmd;
    cmd_d.sh = nxt_sh;
  end

  // Control and pin state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (step_go) begin
        busy_q      <= !last;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command payload and result fields
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      cmd_q      <= cmd_d;
      bit_q      <= nxt_bit;
      ph_q       <= nxt_ph;
      out_scl_q  <= scl_d;
      out_sda_q  <= sda_d;
      out_last_q <= last;
      out_rx_q   <= last ? cur_cmd.rx_val : '0;
      out_ack_q  <= last ? cur_cmd.ack_val : 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scl_level_o       = out_scl_q;
  assign sda_level_o       = out_sda_q;
  assign last_of_command_o = out_last_q;
  assign rx_byte_o         = out_rx_q;
  assign ack_sampled_o     = out_ack_q;

`ifndef SYNTHESIS
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_rx_q == '0 && !out_ack_q)
    else $error("result fields set before the last pin write");
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> bit_q <= LAST_BIT) else $error("bit counter past ack bit");
  a_byte_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cmd_q.kind == KIND_BYTE |-> ph_q != 2'd3)
    else $error("byte phase out of range");
  a_scl_low_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && last && cur_cmd.kind != KIND_STOP |=> !scl_q)
    else $error("SCL left high after start or byte");
`endif

endmodule

`default_nettype wire

@@ rtl/i2c_master_pin_sequencer.sv @@
// A command's first pin write passes the command queue, then the registered back-end output.
// Throughput: one pin write per cycle from the back-end sequencer when not stalled; start 4,
// stop 3, send 27, receive 20 pin writes per command; unused opcodes are taken and give nothing.
// A short command queue lets items be taken while the sequencer is busy.
// Reset (rst_ni low, asynchronous): queue empty, no result pending, SCL and SDA released.
`default_nettype none

module i2c_master_pin_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned FifoDepth = CMD_FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] opcode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       read_direction_i,
  input  wire logic [7:0] slave_bits_i,
  input  wire logic       slave_ack_level_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic            last_of_command_o,
  output logic [7:0]      rx_byte_o,
  output logic            ack_sampled_o
);

  logic full, push, head_valid, pop;
  cmd_t cmd, head;

  i2cms_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .tx_byte_i        (tx_byte_i),
    .read_direction_i (read_direction_i),
    .slave_bits_i     (slave_bits_i),
    .slave_ack_level_i(slave_ack_level_i),
    .full_i           (full),
    .push_o           (push),
    .cmd_o            (cmd)
  );

  i2cms_cmd_fifo #(
    .Depth(FifoDepth)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  i2cms_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scl_level_o      (scl_level_o),
    .sda_level_o      (sda_level_o),
    .last_of_command_o(last_of_command_o),
    .rx_byte_o        (rx_byte_o),
    .ack_sampled_o    (ack_sampled_o)
  );

endmodule

`default_nettype wire

@@ test/i2c_pin_checker.sv @@
`default_nettype none

module i2c_pin_checker
  import i2cms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       read_direction_i,
  input  wire logic [7:0] slave_bits_i,
  input  wire logic       slave_ack_level_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic       scl_level_i,
  input  wire logic       sda_level_i,
  input  wire logic       last_of_command_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       ack_sampled_i,
  output int              errors_o,
  output int              pending_o
);

  // One pin write as the sequencer should report it
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       last;
    logic [7:0] rx;
    logic       ack;
  } pin_write_t;

  pin_write_t pin_writes_due[$];
  logic       scl_now;
  logic       sda_now;
  int         mismatches;

  assign errors_o = mismatches;

  // Drive both lines to the given levels and log the write
  task automatic drive_lines(input logic scl, input logic sda);
    pin_write_t w;
    scl_now = scl;
    sda_now = sda;
    w = '0;
    w.scl = scl;
    w.sda = sda;
    pin_writes_due.push_back(w);
  endtask

  // Work out every pin write of one bus command
  task automatic predict_pin_writes(input logic [2:0] op, input logic [7:0] tx,
                                    input logic rd, input logic [7:0] sb,
                                    input logic ack);
    logic [7:0] shift_byte;
    pin_write_t tail;
    bit         known;
    known = 1'b1;
    case (op)
      OP_START: begin
        drive_lines(scl_now, 1'b1);
        drive_lines(1'b1, sda_now);
        drive_lines(scl_now, 1'b0);
        drive_lines(1'b0, sda_now);
      end
      OP_STOP: begin
        drive_lines(scl_now, 1'b0);
        drive_lines(1'b1, sda_now);
        drive_lines(scl_now, 1'b1);
      end
      OP_SEND_ADDR, OP_SEND_BYTE: begin
        shift_byte = tx;
        if (op == OP_SEND_ADDR && rd) shift_byte = shift_byte | READ_BIT;
        for (int i = 0; i < 8; i++) begin
          drive_lines(scl_now, shift_byte[7-i]);
          drive_lines(1'b1, sda_now);
          drive_lines(1'b0, sda_now);
        end
        // release SDA for the slave's acknowledge
        drive_lines(scl_now, 1'b1);
        drive_lines(1'b1, sda_now);
        drive_lines(1'b0, sda_now);
      end
      OP_RECV_ACK, OP_RECV_NACK: begin
        drive_lines(scl_now, 1'b1);
        for (int i = 0; i < 8; i++) begin
          drive_lines(1'b1, sda_now);
          drive_lines(1'b0, sda_now);
        end
        // ACK low, NACK on the last byte released
        drive_lines(scl_now, op == OP_RECV_NACK);
        drive_lines(1'b1, sda_now);
        drive_lines(1'b0, sda_now);
      end
      default: known = 1'b0;
    endcase
    if (known) begin
      tail = pin_writes_due.pop_back();
      tail.last = 1'b1;
      if (op == OP_RECV_ACK || op == OP_RECV_NACK) tail.rx = sb;
      if (op == OP_SEND_ADDR || op == OP_SEND_BYTE) tail.ack = ack;
      pin_writes_due.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted pin write, then predict from the accepted command
  always @(posedge clk_i or negedge rst_ni) begin
    pin_write_t want;
    if (!rst_ni) begin
      pin_writes_due.delete();
      scl_now    = 1'b1;
      sda_now    = 1'b1;
      mismatches = 0;
      pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pin_writes_due.size() == 0) begin
          $error("pin write with none expected");
          mismatches++;
        end else begin
          want = pin_writes_due.pop_front();
          check_field("scl_level", 8'(want.scl), 8'(scl_level_i));
          check_field("sda_level", 8'(want.sda), 8'(sda_level_i));
          check_field("last_of_command", 8'(want.last), 8'(last_of_command_i));
          check_field("rx_byte", want.rx, rx_byte_i);
          check_field("ack_sampled", 8'(want.ack), 8'(ack_sampled_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_pin_writes(opcode_i, tx_byte_i, read_direction_i, slave_bits_i,
                           slave_ack_level_i);
      pending_o = pin_writes_due.size();
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top
  import i2cms_pkg::*;
();

  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned CMDS_PER_PHASE = 137;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] opcode = 3'd0;
  logic [7:0] tx_byte = 8'd0;
  logic       read_direction = 1'b0;
  logic [7:0] slave_bits = 8'd0;
  logic       slave_ack_level = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       last_of_command;
  logic [7:0] rx_byte;
  logic       ack_sampled;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bus_cmds_issued = 0;
  int idle_cycles = 0;
  int errors;
  int pin_writes_pending;

  always #2 clk_i = ~clk_i;

  i2c_master_pin_sequencer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .tx_byte_i         (tx_byte),
    .read_direction_i  (read_direction),
    .slave_bits_i      (slave_bits),
    .slave_ack_level_i (slave_ack_level),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .scl_level_o       (scl_level),
    .sda_level_o       (sda_level),
    .last_of_command_o (last_of_command),
    .rx_byte_o         (rx_byte),
    .ack_sampled_o     (ack_sampled)
  );

  i2c_pin_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .opcode_i          (opcode),
    .tx_byte_i         (tx_byte),
    .read_direction_i  (read_direction),
    .slave_bits_i      (slave_bits),
    .slave_ack_level_i (slave_ack_level),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .scl_level_i       (scl_level),
    .sda_level_i       (sda_level),
    .last_of_command_i (last_of_command),
    .rx_byte_i         (rx_byte),
    .ack_sampled_i     (ack_sampled),
    .errors_o          (errors),
    .pending_o         (pin_writes_pending)
  );

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one command and hold it until taken; valid stays up for a back-to-back item
  task automatic issue_cmd(input logic [2:0] op, input logic [7:0] tx, input logic rd,
                           input logic [7:0] sb, input logic ack);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid        = 1'b1;
    opcode          = op;
    tx_byte         = tx;
    read_direction  = rd;
    slave_bits      = sb;
    slave_ack_level = ack;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    if (op <= OP_RECV_NACK) bus_cmds_issued++;
  endtask

  task automatic issue_random(input logic [2:0] op);
    issue_cmd(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
              8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Well-formed transfer with random content, now and then a stray command
  task automatic run_bus_transfer();
    int   n_data;
    logic reading;
    issue_random(OP_START);
    reading = 1'($urandom_range(1));
    issue_cmd(OP_SEND_ADDR, 8'($urandom_range(255)), reading, 8'($urandom_range(255)),
              1'($urandom_range(1)));
    n_data = $urandom_range(1, 4);
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(99) < 10) issue_random(3'($urandom_range(7)));
      if (!reading) issue_random(OP_SEND_BYTE);
      else if (i == n_data - 1) issue_random(OP_RECV_NACK);
      else issue_random(OP_RECV_ACK);
    end
    // sometimes leave the bus held for a repeated start
    if ($urandom_range(99) >= 15) issue_random(OP_STOP);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 21;
    rx_idle_pct = 83;

    // Directed: field extremes, every command, ignored opcodes
    issue_cmd(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
    issue_cmd(OP_SEND_ADDR, 8'hFF, 1'b0, 8'h00, 1'b0);
    issue_cmd(OP_SEND_ADDR, 8'h00, 1'b1, 8'hFF, 1'b1);
    issue_cmd(OP_SEND_ADDR, 8'hA4, 1'b0, 8'h00, 1'b1);
    issue_cmd(OP_SEND_ADDR, 8'hA5, 1'b1, 8'h00, 1'b0);
    issue_cmd(OP_SEND_BYTE, 8'h00, 1'b1, 8'h00, 1'b1);
    issue_cmd(OP_SEND_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b0);
    issue_cmd(OP_SEND_BYTE, 8'h5A, 1'b0, 8'hA5, 1'b0);
    issue_cmd(OP_RECV_ACK, 8'hFF, 1'b1, 8'h00, 1'b1);
    issue_cmd(OP_RECV_ACK, 8'h00, 1'b0, 8'hFF, 1'b0);
    issue_cmd(OP_RECV_NACK, 8'h00, 1'b0, 8'h5A, 1'b1);
    issue_cmd(OP_RECV_NACK, 8'hFF, 1'b1, 8'h01, 1'b0);
    issue_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    issue_cmd(3'd6, 8'hFF, 1'b1, 8'hFF, 1'b1);
    issue_cmd(3'd7, 8'h00, 1'b0, 8'h00, 1'b0);
    issue_cmd(OP_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1);
    issue_cmd(OP_START, 8'hFF, 1'b1, 8'hFF, 1'b1);
    issue_cmd(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
    issue_cmd(OP_RECV_ACK, 8'h80, 1'b0, 8'h80, 1'b0);
    issue_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);

    // Random transfers under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 83;
        end
        1: begin
          tx_idle_pct = 83;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (bus_cmds_issued < CMDS_PER_PHASE * (phase + 1)) run_bus_transfer();
    end
    in_valid = 1'b0;

    // Drain, then allow for late or stray pin writes
    while (pin_writes_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
